// ----- rtl/core/y10b_pkg.sv -----
package y10b_pkg;

    localparam int unsigned NumLanes    = 4;
    localparam int unsigned SampleWidth = 10;
    localparam int unsigned PixelWidth  = 8;

    localparam logic [SampleWidth-1:0] BlackLevel = 10'd64;
    localparam logic [SampleWidth-1:0] WhiteLevel = 10'd944;

    // floor(d * 256 / 880) == (d * RangeRecip) >> RangeShift for d < 880
    localparam logic [14:0] RangeRecip = 15'd19066;
    localparam int unsigned RangeShift = 16;

    typedef enum logic
    {
        MODE_VIDEO_RANGE = 1'b0,
        MODE_ROUND       = 1'b1
    } conv_mode_t;

    typedef struct packed
    {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
    } sample_req_t;

    typedef struct packed
    {
        logic [7:0] pixel_0;
        logic [7:0] pixel_1;
        logic [7:0] pixel_2;
        logic [7:0] pixel_3;
    } pixel_req_t;

    typedef logic [SampleWidth-1:0] sample_t;
    typedef logic [PixelWidth-1:0]  pixel_t;

endpackage

// ----- rtl/core/y10b_lane.sv -----
module y10b_lane
(
    input  y10b_pkg::conv_mode_t mode,
    input  y10b_pkg::sample_t    sample,
    output y10b_pkg::pixel_t     pixel
);
    import y10b_pkg::*;

    logic [SampleWidth-1:0] offset;
    logic [24:0]            scaled;
    logic [SampleWidth:0]   rounded;
    pixel_t                 video_pixel;
    pixel_t                 round_pixel;

    assign offset  = sample - BlackLevel;
    assign scaled  = {15'd0, offset} * {10'd0, RangeRecip};
    assign rounded = {1'b0, sample} + 11'd2;

    always_comb
    begin
        if (sample <= BlackLevel)
        begin
            video_pixel = '0;
        end
        else if (sample >= WhiteLevel)
        begin
            video_pixel = '1;
        end
        else
        begin
            video_pixel = scaled[RangeShift +: PixelWidth];
        end
    end

    // saturate the two top codes that round to 256
    assign round_pixel = rounded[SampleWidth] ? '1 : rounded[SampleWidth-1:2];

    always_comb
    begin
        unique case (mode)
            MODE_VIDEO_RANGE: pixel = video_pixel;
            MODE_ROUND:       pixel = round_pixel;
            default:          pixel = video_pixel;
        endcase
    end

endmodule

// ----- rtl/core/y10b_unpack_luma_convert_top.sv -----
// Unpacks one five-byte group of packed big-endian 10-bit grey samples into four
// 8-bit pixels per request. Four conversion lanes run side by side, one per sample;
// their pixels are merged into one registered result. A new group is taken every
// cycle while sample_stall is low (one request per clock) and registered before
// pixel_valid. A two-entry output stage (register plus skid) means sample_stall
// rises only after pixel_stall has held a full result back. conversion_mode 0
// expands video range 64..944 to 0..255, mode 1 rounds to eight bits with
// saturation; write it through cfg_wr_en/cfg_wr_data only while the block is idle.
module y10b_unpack_luma_convert_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  y10b_pkg::sample_req_t sample_data,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output y10b_pkg::pixel_req_t  pixel_data
);
    import y10b_pkg::*;

    conv_mode_t  mode_reg;
    sample_t     samples [NumLanes];
    pixel_t      pixels  [NumLanes];
    pixel_req_t  merged;

    logic        out_valid_reg;
    logic        out_valid_next;
    pixel_req_t  out_data_reg;
    pixel_req_t  out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    pixel_req_t  skid_data_reg;
    pixel_req_t  skid_data_next;
    logic        accept;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_VIDEO_RANGE;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= conv_mode_t'(cfg_wr_data);
        end
    end

    assign samples[0] = {sample_data.byte_0, sample_data.byte_1[7:6]};
    assign samples[1] = {sample_data.byte_1[5:0], sample_data.byte_2[7:4]};
    assign samples[2] = {sample_data.byte_2[3:0], sample_data.byte_3[7:2]};
    assign samples[3] = {sample_data.byte_3[1:0], sample_data.byte_4};

    for (genvar i = 0; i < NumLanes; i++)
    begin : g_lane
        y10b_lane u_lane
        (
            .mode   (mode_reg),
            .sample (samples[i]),
            .pixel  (pixels[i])
        );
    end

    assign merged.pixel_0 = pixels[0];
    assign merged.pixel_1 = pixels[1];
    assign merged.pixel_2 = pixels[2];
    assign merged.pixel_3 = pixels[3];

    assign sample_stall = skid_valid_reg;
    assign accept       = sample_valid && !skid_valid_reg;
    assign out_free     = !out_valid_reg || !pixel_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            // advance: skid first, then the new request
            out_valid_next  = skid_valid_reg || accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : merged;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            // hold the output, park the new request
            skid_valid_next = 1'b1;
            skid_data_next  = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_data_reg;

endmodule
